// ===== rtl/core/kst_sel_pkg.sv =====
// Package for the spanning tree edge selector.
// Holds payload structs, queue entry type and sizing constants.
// No dependencies.
`timescale 1ns / 1ps

package kst_sel_pkg;

    localparam int MAX_NODES   = 64;
    localparam int MAX_EDGES   = 256;
    localparam int NODE_W      = $clog2(MAX_NODES);
    localparam int EDGE_W      = $clog2(MAX_EDGES);
    localparam int TOTAL_W     = EDGE_W + 1;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int KEY_W       = 16 + 32 + EDGE_W;

    typedef struct packed {
        logic [6:0]         from_node;
        logic [6:0]         to_node;
        logic [15:0]        effort;
        logic signed [31:0] pay;
        logic               last_edge;
    } in_item_t;

    typedef struct packed {
        logic [8:0] edge_index;
        logic       last_result;
        logic       edges_dropped;
    } out_item_t;

    typedef struct packed {
        in_item_t item;
        logic     dead;
    } queue_entry_t;

endpackage

// ===== rtl/core/kst_sel_front.sv =====
// Front end of the edge selector: accepts input beats and queues them.
// Marks edges that can never join the tree. Depends on kst_sel_pkg.
`timescale 1ns / 1ps

module kst_sel_front (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  kst_sel_pkg::in_item_t      s_data,
    output logic                       q_valid,
    input  logic                       q_ready,
    output kst_sel_pkg::queue_entry_t  q_data
);
    import kst_sel_pkg::*;

    queue_entry_t          queue_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]     wr_ptr_reg;
    logic [QPTR_W-1:0]     rd_ptr_reg;
    logic [QPTR_W:0]       count_reg;
    logic                  push;
    logic                  pop;
    queue_entry_t          entry;

    assign s_ready = (count_reg != (QPTR_W+1)'(QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_data  = queue_mem[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    always_comb begin
        entry.item = s_data;
        entry.dead = (s_data.from_node == s_data.to_node) || (s_data.from_node == 7'd0)
                     || (s_data.to_node == 7'd0);
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            queue_mem[wr_ptr_reg] <= entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= (QPTR_W+1)'(QUEUE_DEPTH))
        else $error("queue count above depth");
    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == (QPTR_W+1)'(QUEUE_DEPTH)) && !pop |=> count_reg == $past(count_reg))
        else $error("queue grew while full");
    a_pop_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        pop && !push |=> count_reg == $past(count_reg) - 1'b1)
        else $error("pop did not drain queue");

endmodule

// ===== rtl/core/kst_sel_back.sv =====
// Back end of the edge selector: edge store, ordered selection passes,
// union-find over node roots and the result register. Depends on kst_sel_pkg.
`timescale 1ns / 1ps

module kst_sel_back (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic [6:0]                 node_count,
    input  logic                       q_valid,
    output logic                       q_ready,
    input  kst_sel_pkg::queue_entry_t  q_data,
    output logic                       m_valid,
    input  logic                       m_ready,
    output kst_sel_pkg::out_item_t     m_data
);
    import kst_sel_pkg::*;

    typedef enum logic [3:0] {
        ST_LOAD, ST_CLR, ST_NEXT, ST_SCAN, ST_EVAL,
        ST_FIND_RD, ST_FIND_CK, ST_UNION, ST_PUSH, ST_FIN
    } state_t;

    state_t               state_reg;
    queue_entry_t         edge_mem [MAX_EDGES];
    logic [NODE_W-1:0]    uf_mem [MAX_NODES];

    logic [TOTAL_W-1:0]   total_reg;
    logic                 ovf_reg;
    logic [6:0]           nc_reg;
    logic [NODE_W-1:0]    clr_cnt_reg;
    logic [TOTAL_W-1:0]   issue_reg;
    logic                 rd_vld_reg;
    queue_entry_t         rd_q_reg;
    logic [EDGE_W-1:0]    rd_idx_reg;
    logic                 best_found_reg;
    logic [KEY_W-1:0]     best_key_reg;
    queue_entry_t         best_reg;
    logic [EDGE_W-1:0]    best_idx_reg;
    logic                 have_last_reg;
    logic [KEY_W-1:0]     last_key_reg;
    logic [NODE_W-1:0]    x_reg;
    logic                 phase_reg;
    logic [NODE_W-1:0]    root_b_reg;
    logic [NODE_W-1:0]    root_a_reg;
    logic [NODE_W-1:0]    uf_q_reg;
    logic                 pend_valid_reg;
    logic [8:0]           pend_idx_reg;
    logic [NODE_W-1:0]    acc_reg;
    logic                 m_valid_reg;
    out_item_t            m_data_reg;

    logic                 out_free;
    logic                 emit_beat;
    logic                 load_wr;
    logic                 uf_wr;
    logic [NODE_W-1:0]    uf_wr_addr;
    logic [NODE_W-1:0]    uf_wr_data;
    logic [KEY_W-1:0]     cand_key;
    logic                 cand_ok;
    logic                 ends_ok;
    logic [6:0]           nc_eff;

    function automatic logic [KEY_W-1:0] edge_key(input queue_entry_t e,
                                                  input logic [EDGE_W-1:0] idx);
        edge_key = {e.item.effort, e.item.pay ^ 32'h7FFF_FFFF, idx};
    endfunction

    assign out_free  = !m_valid_reg || m_ready;
    assign emit_beat = pend_valid_reg && out_free
                       && ((state_reg == ST_PUSH) || (state_reg == ST_FIN));
    assign q_ready   = (state_reg == ST_LOAD);
    assign load_wr   = q_valid && q_ready && !total_reg[EDGE_W];
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    assign cand_key = edge_key(rd_q_reg, rd_idx_reg);
    assign cand_ok  = (!have_last_reg || (cand_key > last_key_reg))
                      && (!best_found_reg || (cand_key < best_key_reg));
    assign ends_ok  = !best_reg.dead && (best_reg.item.from_node <= nc_reg)
                      && (best_reg.item.to_node <= nc_reg);

    always_comb begin
        if (node_count == 7'd0) begin
            nc_eff = 7'd1;
        end else if (node_count > 7'(MAX_NODES)) begin
            nc_eff = 7'(MAX_NODES);
        end else begin
            nc_eff = node_count;
        end
    end

    always_comb begin
        uf_wr      = 1'b0;
        uf_wr_addr = clr_cnt_reg;
        uf_wr_data = clr_cnt_reg;
        if (state_reg == ST_CLR) begin
            uf_wr = 1'b1;
        end else if ((state_reg == ST_UNION) && (root_a_reg != root_b_reg)) begin
            uf_wr      = 1'b1;
            uf_wr_addr = root_a_reg;
            uf_wr_data = root_b_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_wr) begin
            edge_mem[total_reg[EDGE_W-1:0]] <= q_data;
        end
        rd_q_reg   <= edge_mem[issue_reg[EDGE_W-1:0]];
        rd_idx_reg <= issue_reg[EDGE_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (uf_wr) begin
            uf_mem[uf_wr_addr] <= uf_wr_data;
        end
        uf_q_reg <= uf_mem[x_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_LOAD;
            total_reg      <= '0;
            ovf_reg        <= 1'b0;
            nc_reg         <= 7'(MAX_NODES);
            clr_cnt_reg    <= '0;
            issue_reg      <= '0;
            rd_vld_reg     <= 1'b0;
            best_found_reg <= 1'b0;
            have_last_reg  <= 1'b0;
            phase_reg      <= 1'b0;
            pend_valid_reg <= 1'b0;
            acc_reg        <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (emit_beat) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_LOAD: begin
                    if (q_valid) begin
                        if (total_reg[EDGE_W]) begin
                            ovf_reg <= 1'b1;
                        end else begin
                            total_reg <= total_reg + 1'b1;
                        end
                        if (q_data.item.last_edge) begin
                            nc_reg        <= nc_eff;
                            clr_cnt_reg   <= '0;
                            have_last_reg <= 1'b0;
                            acc_reg       <= '0;
                            state_reg     <= ST_CLR;
                        end
                    end
                end
                ST_CLR: begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == NODE_W'(MAX_NODES - 1)) begin
                        state_reg <= ST_NEXT;
                    end
                end
                ST_NEXT: begin
                    if ((7'(acc_reg) + 7'd1) < nc_reg) begin
                        issue_reg      <= '0;
                        rd_vld_reg     <= 1'b0;
                        best_found_reg <= 1'b0;
                        state_reg      <= ST_SCAN;
                    end else begin
                        state_reg <= ST_FIN;
                    end
                end
                ST_SCAN: begin
                    if (issue_reg < total_reg) begin
                        issue_reg  <= issue_reg + 1'b1;
                        rd_vld_reg <= 1'b1;
                    end else begin
                        rd_vld_reg <= 1'b0;
                    end
                    if (rd_vld_reg && cand_ok) begin
                        best_found_reg <= 1'b1;
                        best_key_reg   <= cand_key;
                        best_reg       <= rd_q_reg;
                        best_idx_reg   <= rd_idx_reg;
                    end
                    if ((issue_reg == total_reg) && !rd_vld_reg) begin
                        state_reg <= ST_EVAL;
                    end
                end
                ST_EVAL: begin
                    if (!best_found_reg) begin
                        state_reg <= ST_FIN;
                    end else begin
                        have_last_reg <= 1'b1;
                        last_key_reg  <= best_key_reg;
                        if (ends_ok) begin
                            x_reg     <= NODE_W'(best_reg.item.to_node - 7'd1);
                            phase_reg <= 1'b0;
                            state_reg <= ST_FIND_RD;
                        end else begin
                            state_reg <= ST_NEXT;
                        end
                    end
                end
                ST_FIND_RD: begin
                    state_reg <= ST_FIND_CK;
                end
                ST_FIND_CK: begin
                    if (uf_q_reg == x_reg) begin
                        if (!phase_reg) begin
                            root_b_reg <= x_reg;
                            x_reg      <= NODE_W'(best_reg.item.from_node - 7'd1);
                            phase_reg  <= 1'b1;
                            state_reg  <= ST_FIND_RD;
                        end else begin
                            root_a_reg <= x_reg;
                            state_reg  <= ST_UNION;
                        end
                    end else begin
                        x_reg     <= uf_q_reg;
                        state_reg <= ST_FIND_RD;
                    end
                end
                ST_UNION: begin
                    if (root_a_reg == root_b_reg) begin
                        state_reg <= ST_NEXT;
                    end else begin
                        state_reg <= ST_PUSH;
                    end
                end
                ST_PUSH: begin
                    if (!pend_valid_reg || out_free) begin
                        if (pend_valid_reg) begin
                            m_data_reg.edge_index    <= pend_idx_reg;
                            m_data_reg.last_result   <= 1'b0;
                            m_data_reg.edges_dropped <= ovf_reg;
                        end
                        pend_valid_reg <= 1'b1;
                        pend_idx_reg   <= 9'(best_idx_reg) + 9'd1;
                        acc_reg        <= acc_reg + 1'b1;
                        state_reg      <= ST_NEXT;
                    end
                end
                ST_FIN: begin
                    if (!pend_valid_reg) begin
                        total_reg <= '0;
                        ovf_reg   <= 1'b0;
                        acc_reg   <= '0;
                        state_reg <= ST_LOAD;
                    end else if (out_free) begin
                        m_data_reg.edge_index    <= pend_idx_reg;
                        m_data_reg.last_result   <= 1'b1;
                        m_data_reg.edges_dropped <= ovf_reg;
                        pend_valid_reg           <= 1'b0;
                    end
                end
                default: begin
                    state_reg <= ST_LOAD;
                end
            endcase
        end
    end

    a_total_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        total_reg <= TOTAL_W'(MAX_EDGES))
        else $error("edge total above capacity");
    a_no_pend_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LOAD) |-> !pend_valid_reg)
        else $error("pending result left while loading");
    a_acc_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_LOAD) |-> (7'(acc_reg) < nc_reg))
        else $error("accepted count reached node count");
    a_push_makes_pend: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PUSH) && out_free |=> pend_valid_reg)
        else $error("push did not hold a pending result");

endmodule

// ===== rtl/core/kruskal_spanning_tree_selector_unit.sv =====
// Top level of the spanning tree edge selector: node count register,
// front queue and back end. Depends on kst_sel_pkg, kst_sel_front, kst_sel_back.
//
//   Channel   Direction  Handshake               Beat payload
//   s_        in         s_valid / s_ready       in_item_t (one edge)
//   m_        out        m_valid / m_ready       out_item_t (one tree edge)
//   cfg_      in         cfg_wr_en               node_count
//
// Edges load at one per cycle while the back end is loading. After the last
// edge, selection clears every union-find entry, then scans all stored edges
// once per sorted position, with a read and a check per root lookup step.
// Reset is synchronous, active low. Either side may stall independently;
// the four-beat queue absorbs input while the back end is busy.
`timescale 1ns / 1ps

module kruskal_spanning_tree_selector_unit (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  kst_sel_pkg::in_item_t   s_data,
    output logic                    m_valid,
    input  logic                    m_ready,
    output kst_sel_pkg::out_item_t  m_data,
    input  logic                    cfg_wr_en,
    input  logic [6:0]              cfg_wr_data
);
    import kst_sel_pkg::*;

    logic [6:0]    node_count_reg;
    logic          q_valid;
    logic          q_ready;
    queue_entry_t  q_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_count_reg <= 7'(MAX_NODES);
        end else if (cfg_wr_en) begin
            node_count_reg <= cfg_wr_data;
        end
    end

    kst_sel_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_data  (q_data)
    );

    kst_sel_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .node_count (node_count_reg),
        .q_valid    (q_valid),
        .q_ready    (q_ready),
        .q_data     (q_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule
